[src/packet_buffer_start_time_queue_top_macros.svh]
// Assertion macros for the packet buffer start time queue.
// Used by the top level; expects clk and rst_n in scope.
`ifndef PACKET_BUFFER_START_TIME_QUEUE_TOP_MACROS_SVH
`define PACKET_BUFFER_START_TIME_QUEUE_TOP_MACROS_SVH

`define PBSTQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define PBSTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/pbstq_pkg.sv]
// Shared types and constants for the packet buffer start time queue.
// No dependencies.
package pbstq_pkg;

    localparam int TIME_W           = 32;
    localparam int ARR_W            = 31;
    localparam int PROC_W           = 16;
    localparam int CAP_W            = 9;
    localparam int BUFFER_DEPTH_DEF = 256;
    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    typedef enum logic
    {
        ST_IDLE,
        ST_RUN
    } pbstq_state_t;

    typedef struct packed
    {
        logic              shift;
        logic              push;
        logic [TIME_W-1:0] data;
    } pbstq_cmd_t;

endpackage

[src/pbstq_in_if.sv]
// Input channel: one packet item with arrival and processing time.
// Depends on pbstq_pkg.
interface pbstq_in_if
    import pbstq_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ARR_W-1:0]  arrival_time;
    logic [PROC_W-1:0] processing_time;

    modport source (output valid, output arrival_time, output processing_time, input ready);
    modport sink   (input valid, input arrival_time, input processing_time, output ready);
endinterface

[src/pbstq_out_if.sv]
// Output channel: one result item with drop flag and start time.
// Depends on pbstq_pkg.
interface pbstq_out_if
    import pbstq_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              dropped;
    logic [TIME_W-1:0] start_time;

    modport source (output valid, output dropped, output start_time, input ready);
    modport sink   (input valid, input dropped, input start_time, output ready);
endinterface

[src/pbstq_cell.sv]
// One queue cell holding a single finish time.
// Depends on pbstq_pkg.
module pbstq_cell
    import pbstq_pkg::*;
(
    input  logic              clk,
    input  pbstq_cmd_t        cmd,
    input  logic              sel,
    input  logic [TIME_W-1:0] next_data,
    output logic [TIME_W-1:0] data
);
    logic [TIME_W-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.shift)
        begin
            data_reg <= next_data;
        end
        else if (cmd.push && sel)
        begin
            data_reg <= cmd.data;
        end
    end

    assign data = data_reg;
endmodule

[src/pbstq_chain.sv]
// Row of cells forming the finish time queue, head at cell zero.
// Depends on pbstq_pkg and pbstq_cell.
module pbstq_chain
    import pbstq_pkg::*;
#(
    parameter int DEPTH = BUFFER_DEPTH_DEF,
    parameter int OCC_W = $clog2(DEPTH + 1)
)
(
    input  logic              clk,
    input  pbstq_cmd_t        cmd,
    input  logic [OCC_W-1:0]  occ,
    output logic [TIME_W-1:0] head
);
    logic [TIME_W-1:0] cell_data [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [TIME_W-1:0] nbr;
        if (i == DEPTH - 1)
        begin : g_last
            assign nbr = cell_data[i];
        end
        else
        begin : g_mid
            assign nbr = cell_data[i+1];
        end

        pbstq_cell u_cell
        (
            .clk       (clk),
            .cmd       (cmd),
            .sel       (occ == OCC_W'(i)),
            .next_data (nbr),
            .data      (cell_data[i])
        );
    end

    assign head = cell_data[0];
endmodule

[src/packet_buffer_start_time_queue_top.sv]
// Top level of the packet buffer start time queue: control, timing state, output register.
// Depends on pbstq_pkg, pbstq_in_if, pbstq_out_if, pbstq_chain and the macros header.
//
//  channel | dir | handshake     | payload
//  in_ch   | in  | valid/ready   | arrival_time[30:0], processing_time[15:0]
//  out_ch  | out | valid/ready   | dropped, start_time[31:0]
//  cfg     | in  | cfg_we        | cfg_data[8:0] (capacity)
//
// An item is accepted in the idle state; then the expired packets are removed
// from the head, each queued packet once, one per cycle by the cell chain.
// The result waits in an output register; a full register stalls the decision cycle.
// Reset empties the queue, zeroes the clock and last finish, sets capacity to 256.
`include "packet_buffer_start_time_queue_top_macros.svh"
module packet_buffer_start_time_queue_top
    import pbstq_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    pbstq_in_if.sink         in_ch,
    pbstq_out_if.source      out_ch,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_data
);
    localparam int OCC_W = $clog2(BUFFER_DEPTH + 1);
    localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

    pbstq_state_t      state_reg, state_next;
    logic [PROC_W-1:0] proc_reg, proc_next;
    logic [TIME_W-1:0] cur_reg, cur_next;
    logic [TIME_W-1:0] last_reg, last_next;
    logic [OCC_W-1:0]  occ_reg, occ_next;
    logic [CAP_W-1:0]  cap_reg;
    logic              out_valid_reg, out_valid_next;
    logic              out_dropped_reg, out_dropped_next;
    logic [TIME_W-1:0] out_start_reg, out_start_next;

    logic [TIME_W-1:0] head;
    logic              pop;
    logic              commit;
    logic              full;
    logic [TIME_W-1:0] start;
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] finish;
    logic [TIME_W-1:0] arr_ext;
    pbstq_cmd_t        cmd;

    pbstq_chain #(.DEPTH(BUFFER_DEPTH), .OCC_W(OCC_W)) u_chain
    (
        .clk  (clk),
        .cmd  (cmd),
        .occ  (occ_reg),
        .head (head)
    );

    assign arr_ext = TIME_W'(in_ch.arrival_time);
    assign pop     = (state_reg == ST_RUN) && (occ_reg != '0) && (head <= cur_reg);
    assign commit  = (state_reg == ST_RUN) && !pop && (!out_valid_reg || out_ch.ready);
    assign full    = (CMP_W'(occ_reg) >= CMP_W'(cap_reg)) ||
                     (occ_reg == OCC_W'(BUFFER_DEPTH));
    assign start   = (occ_reg == '0) ? cur_reg : last_reg;
    assign sum     = {1'b0, start} + (TIME_W+1)'(proc_reg);
    assign finish  = sum[TIME_W] ? '1 : sum[TIME_W-1:0];

    assign in_ch.ready       = (state_reg == ST_IDLE);
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.dropped    = out_dropped_reg;
    assign out_ch.start_time = out_start_reg;

    always_comb
    begin
        state_next       = state_reg;
        proc_next        = proc_reg;
        cur_next         = cur_reg;
        last_next        = last_reg;
        occ_next         = occ_reg;
        out_valid_next   = out_valid_reg;
        out_dropped_next = out_dropped_reg;
        out_start_next   = out_start_reg;
        cmd.shift        = 1'b0;
        cmd.push         = 1'b0;
        cmd.data         = finish;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    proc_next  = in_ch.processing_time;
                    cur_next   = (arr_ext > cur_reg) ? arr_ext : cur_reg;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (pop)
                begin
                    cmd.shift = 1'b1;
                    occ_next  = occ_reg - OCC_W'(1);
                end
                else if (commit)
                begin
                    out_valid_next   = 1'b1;
                    out_dropped_next = full;
                    out_start_next   = full ? '0 : start;
                    state_next       = ST_IDLE;
                    if (!full)
                    begin
                        cmd.push  = 1'b1;
                        occ_next  = occ_reg + OCC_W'(1);
                        last_next = finish;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_reg       <= '0;
            last_reg      <= '0;
            occ_reg       <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            last_reg      <= last_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        proc_reg        <= proc_next;
        out_dropped_reg <= out_dropped_next;
        out_start_reg   <= out_start_next;
    end

    `PBSTQ_ASSERT_IMPLY(a_occ_bound, 1'b1, occ_reg <= OCC_W'(BUFFER_DEPTH), "occupancy above depth")
    `PBSTQ_ASSERT_NEXT(a_accept_run, in_ch.valid && in_ch.ready, state_reg == ST_RUN, "accept without run")
    `PBSTQ_ASSERT_NEXT(a_push_count, commit && !full, occ_reg == $past(occ_reg) + OCC_W'(1), "push lost")
endmodule

[tb/testbench.sv]
// Self-checking testbench for packet_buffer_start_time_queue_top: drives packet items, predicts
// start times and drops with a scoreboard class, and checks every result item in order.
// Depends on pbstq_pkg, pbstq_in_if, pbstq_out_if and the top level.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pbstq_pkg::*;

    typedef struct packed
    {
        logic              dropped;
        logic [TIME_W-1:0] start_time;
    } outcome_t;

    class schedule_board;
        logic [TIME_W-1:0] queued_finish[$];
        logic [TIME_W-1:0] sched_clock;
        logic [TIME_W-1:0] newest_finish;
        logic [CAP_W-1:0]  capacity;
        outcome_t          start_queue[$];
        int                errors;

        function new();
            sched_clock   = '0;
            newest_finish = '0;
            capacity      = CAP_RESET;
            errors        = 0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] value);
            capacity = value;
        endfunction

        function int pending();
            return start_queue.size();
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("mismatch at %0t ns: %s", $time, what);
        endtask

        function void admit_packet(logic [ARR_W-1:0] arrival, logic [PROC_W-1:0] service);
            logic [TIME_W:0]   sum;
            logic [TIME_W-1:0] start;
            int                limit;
            outcome_t          res;
            if ({1'b0, arrival} > sched_clock)
                sched_clock = {1'b0, arrival};
            while (queued_finish.size() > 0 && queued_finish[0] <= sched_clock)
                void'(queued_finish.pop_front());
            limit = (capacity > BUFFER_DEPTH_DEF) ? BUFFER_DEPTH_DEF : int'(capacity);
            if (queued_finish.size() >= limit)
            begin
                res.dropped    = 1'b1;
                res.start_time = '0;
            end
            else
            begin
                start = (queued_finish.size() == 0) ? sched_clock : newest_finish;
                sum = {1'b0, start} + (TIME_W+1)'(service);
                newest_finish = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
                queued_finish.push_back(newest_finish);
                res.dropped    = 1'b0;
                res.start_time = start;
            end
            start_queue.push_back(res);
        endfunction

        task match_result(logic dropped, logic [TIME_W-1:0] start_time);
            outcome_t want;
            if (start_queue.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result dropped=%0b start=%0d",
                                          dropped, start_time));
                return;
            end
            want = start_queue.pop_front();
            if (dropped !== want.dropped)
                report_mismatch($sformatf("dropped %0b, want %0b", dropped, want.dropped));
            if (start_time !== want.start_time)
                report_mismatch($sformatf("start_time %0d, want %0d",
                                          start_time, want.start_time));
        endtask
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CAP_W-1:0] cfg_data;

    pbstq_in_if  pkt_ch ();
    pbstq_out_if res_ch ();

    schedule_board board;
    int unsigned   arrival_base = 0;
    int            in_idle_pct = 0;
    int            out_idle_pct = 0;
    int            stall_left = 0;

    packet_buffer_start_time_queue_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (pkt_ch),
        .out_ch   (res_ch),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                res_ch.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                res_ch.ready = 1'b1;
                if (out_idle_pct != 0 && $urandom_range(1, 100) <= out_idle_pct)
                    stall_left = $urandom_range(1, 5);
            end
        end
    end

    always @(posedge clk)
        if (rst_n && res_ch.valid && res_ch.ready)
            board.match_result(res_ch.dropped, res_ch.start_time);

    task automatic send_packet(input logic [ARR_W-1:0] arrival,
                               input logic [PROC_W-1:0] service);
        int gap;
        @(negedge clk);
        if (in_idle_pct != 0 && $urandom_range(1, 100) <= in_idle_pct)
        begin
            gap = $urandom_range(1, 5);
            pkt_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        pkt_ch.valid           = 1'b1;
        pkt_ch.arrival_time    = arrival;
        pkt_ch.processing_time = service;
        @(posedge clk);
        while (!pkt_ch.ready)
            @(posedge clk);
        board.admit_packet(arrival, service);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        @(negedge clk);
        pkt_ch.valid = 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        cfg_we   = 1'b1;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
        board.set_capacity(value);
    endtask

    task automatic send_random(input int unsigned proc_max, input int unsigned gap_max);
        logic [ARR_W-1:0]  arrival;
        logic [PROC_W-1:0] service;
        int unsigned       next;
        if ($urandom_range(0, 9) == 0)
            arrival = ARR_W'($urandom_range(0, arrival_base));
        else
        begin
            next = arrival_base + $urandom_range(0, gap_max);
            if (next > 32'h7FFF_FFFF)
                next = 32'h7FFF_FFFF;
            arrival_base = next;
            arrival = next[ARR_W-1:0];
        end
        if ($urandom_range(0, 19) == 0)
            service = '0;
        else
            service = PROC_W'($urandom_range(0, proc_max));
        send_packet(arrival, service);
    endtask

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 10;
            default: return 35;
        endcase
    endfunction

    task automatic run_phase(input logic [CAP_W-1:0] cap, input int count);
        int unsigned proc_max;
        int unsigned gap_max;
        case ($urandom_range(0, 3))
            0: proc_max = 15;
            1: proc_max = 255;
            2: proc_max = 4095;
            default: proc_max = 65535;
        endcase
        gap_max = proc_max * $urandom_range(1, 8) / 4;
        write_capacity(cap);
        in_idle_pct  = pick_idle_pct();
        out_idle_pct = pick_idle_pct();
        arrival_base = arrival_base + $urandom_range(0, 1 << 20);
        repeat (count) send_random(proc_max, gap_max);
    endtask

    initial
    begin
        board = new();
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_data               = '0;
        pkt_ch.valid           = 1'b0;
        pkt_ch.arrival_time    = '0;
        pkt_ch.processing_time = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        in_idle_pct  = 20;
        out_idle_pct = 20;
        send_packet(31'd0, 16'd0);
        send_packet(31'd0, 16'hFFFF);
        send_packet(31'd10, 16'd5);
        // arrival behind the clock
        send_packet(31'd5, 16'd1);
        send_packet(31'd70000, 16'd0);
        send_packet(31'd70000, 16'd3);
        repeat (8) send_packet(31'd80000, 16'd100);
        // shrink capacity below occupancy
        write_capacity(9'd2);
        repeat (3) send_packet(31'd80000, 16'd100);
        send_packet(31'd80700, 16'd1);
        write_capacity(9'd0);
        send_packet(31'd81000, 16'd7);
        send_packet(31'd82000, 16'd0);
        write_capacity(9'd1);
        send_packet(31'd90000, 16'd50);
        send_packet(31'd90010, 16'd50);
        send_packet(31'd90050, 16'd1);
        arrival_base = 90050;

        // fill the whole buffer
        write_capacity(9'd511);
        arrival_base = arrival_base + (1 << 20);
        repeat (300) send_random(65535, 3);

        run_phase(9'd256, 115);
        run_phase(9'd257, 115);
        run_phase(9'd1, 115);
        run_phase(9'd3, 115);
        run_phase(9'd16, 115);
        run_phase(CAP_W'($urandom_range(0, 511)), 115);
        run_phase(9'd255, 115);
        run_phase(9'd64, 115);

        write_capacity(CAP_W'($urandom_range(0, 511)));
        in_idle_pct  = 0;
        out_idle_pct = 0;
        arrival_base = 32'h7C00_0000;
        repeat (75) send_random(65535, 65535);
        send_packet(31'h7FFF_FFFF, 16'hFFFF);
        send_packet(31'h7FFF_FFFF, 16'd0);
        send_packet(31'd0, 16'd1);

        @(negedge clk);
        pkt_ch.valid = 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
        if (board.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
